/* rtl/assert_macros.svh */
// Assertion macros used by the top RTL file of the IQ phase block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, off while reset is asserted.
`define IQA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iq_phase_atan2: assertion failed");

// Next-cycle implication, checked also through reset.
`define IQA_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("iq_phase_atan2: assertion failed");

`else

`define IQA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IQA_ASSERT_NXT(lbl, clk, ante, cons)

`endif

`endif

/* rtl/iqa_pkg.sv */
// Shared types and constants of the IQ phase CORDIC block.
`default_nettype none

package iqa_pkg;

  // Fraction bits added below the sample before the micro-rotations
  localparam int GUARD_BITS = 16;

  // Angle accumulator: 32 bits, 2^31 stands for pi
  localparam int Z_BITS          = 32;
  localparam int ANGLE_TABLE_LEN = 32;

  localparam logic [Z_BITS-1:0] Z_PLUS_HALF_PI  = 32'h4000_0000;
  localparam logic [Z_BITS-1:0] Z_MINUS_HALF_PI = 32'hC000_0000;

  // atan(2^-k) scaled so that 2^31 is pi, rounded to nearest
  localparam logic [Z_BITS-1:0] ARC_TABLE [0:ANGLE_TABLE_LEN-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Side flags that ride along with each item
  typedef struct packed {
    logic last;   // end of buffer marker
    logic zero;   // input vector was (0,0)
  } iqa_ctl_t;

endpackage

`default_nettype wire

/* rtl/iqa_pre.sv */
// Input stage: quadrant pre-rotation into the right half plane and zero detect.
`default_nettype none

module iqa_pre
  import iqa_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int W           = 35
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] q_sample,
  input  wire logic                    last_sample,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [W-1:0]          x_out,
  output logic signed [W-1:0]          y_out,
  output logic [Z_BITS-1:0]            z_out,
  output iqa_ctl_t                     ctl_out
);

  localparam int EXT_BITS = W - SAMPLE_BITS - GUARD_BITS;

  logic                 vld_r;
  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic [Z_BITS-1:0]    z_r, z_nxt;
  iqa_ctl_t             ctl_r, ctl_nxt;
  logic signed [W-1:0]  xi, yq;

  assign in_ready = !vld_r || out_ready;

  // Scale samples by the guard fraction
  assign xi = {{EXT_BITS{i_sample[SAMPLE_BITS-1]}}, i_sample, {GUARD_BITS{1'b0}}};
  assign yq = {{EXT_BITS{q_sample[SAMPLE_BITS-1]}}, q_sample, {GUARD_BITS{1'b0}}};

  // Rotate left half plane by +-pi/2
  always_comb begin
    x_nxt = xi;
    y_nxt = yq;
    z_nxt = '0;
    if (xi[W-1]) begin
      if (!yq[W-1]) begin
        x_nxt = yq;
        y_nxt = -xi;
        z_nxt = Z_PLUS_HALF_PI;
      end else begin
        x_nxt = -yq;
        y_nxt = xi;
        z_nxt = Z_MINUS_HALF_PI;
      end
    end
    ctl_nxt.last = last_sample;
    ctl_nxt.zero = (i_sample == '0) && (q_sample == '0);
  end

  // Hold valid while the next cell stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // Load the item on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign out_valid = vld_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;
  assign ctl_out   = ctl_r;

endmodule

`default_nettype wire

/* rtl/iqa_cell.sv */
// One CORDIC vectoring micro-rotation cell with its own pipeline register.
`default_nettype none

module iqa_cell
  import iqa_pkg::*;
#(
  parameter int W   = 35,
  parameter int IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [W-1:0]  x_in,
  input  wire logic signed [W-1:0]  y_in,
  input  wire logic [Z_BITS-1:0]    z_in,
  input  wire iqa_ctl_t             ctl_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [W-1:0]       x_out,
  output logic signed [W-1:0]       y_out,
  output logic [Z_BITS-1:0]         z_out,
  output iqa_ctl_t                  ctl_out
);

  localparam logic [Z_BITS-1:0] ARC = ARC_TABLE[IDX];

  logic                 vld_r;
  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic signed [W-1:0]  xs, ys;
  logic [Z_BITS-1:0]    z_r, z_nxt;
  iqa_ctl_t             ctl_r;

  assign in_ready = !vld_r || out_ready;

  // Floor-shifted copies for this rotation step
  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;

  // Rotate toward the real axis, steering by the sign of y
  always_comb begin
    if (!y_in[W-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ARC;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ARC;
    end
  end

  // Hold valid while the neighbor stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // Advance the item into this cell
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      ctl_r <= ctl_in;
    end
  end

  assign out_valid = vld_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;
  assign ctl_out   = ctl_r;

endmodule

`default_nettype wire

/* rtl/iqa_post.sv */
// Output stage: round the angle to the phase width and hold the result item.
`default_nettype none

module iqa_post
  import iqa_pkg::*;
#(
  parameter int PHASE_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [Z_BITS-1:0]       z_in,
  input  wire iqa_ctl_t                ctl_in,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [PHASE_BITS-1:0] phase,
  output logic                         last_result
);

  localparam int DROP = Z_BITS - PHASE_BITS;

  logic                         vld_r;
  logic signed [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic                         last_r;
  logic [Z_BITS-1:0]            z_rnd;

  assign in_ready = !vld_r || out_ready;

  // Add half an output LSB, modulo 2^32
  generate
    if (DROP > 0) begin : g_round
      assign z_rnd = z_in + (Z_BITS'(1) << (DROP - 1));
    end else begin : g_exact
      assign z_rnd = z_in;
    end
  endgenerate

  // Zero vector forces phase zero
  always_comb begin
    if (ctl_in.zero) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = z_rnd[Z_BITS-1 -: PHASE_BITS];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      phase_r <= phase_nxt;
      last_r  <= ctl_in.last;
    end
  end

  assign out_valid   = vld_r;
  assign phase       = phase_r;
  assign last_result = last_r;

endmodule

`default_nettype wire

/* rtl/iq_phase_atan2.sv */
// Pipeline from input item to result item: one pre-rotation stage, one cell per
// micro-rotation, one output register.
// Throughput: one item per cycle; every cell holds one item, and a stall at the
// output backs up cell by cell, so empty cells still take new items.
// Reset: rst_n is synchronous and clears only the valid bit of each cell.
`default_nettype none

`include "assert_macros.svh"

module iq_phase_atan2
  import iqa_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int PHASE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // in_tdata: i_sample [SAMPLE_BITS-1:0], q_sample [2*SAMPLE_BITS-1:SAMPLE_BITS], zero pad
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic                 in_tlast,
  // out_tdata: phase [PHASE_BITS-1:0], zero pad
  output logic [((PHASE_BITS+7)/8)*8-1:0] out_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic                      out_tlast
);

  localparam int OUT_W = ((PHASE_BITS+7)/8)*8;
  localparam int N     = CORDIC_STAGES;
  // Room for the CORDIC gain and the pre-rotation negation
  localparam int W     = SAMPLE_BITS + GUARD_BITS + 3;

  logic signed [SAMPLE_BITS-1:0] i_sample, q_sample;
  logic signed [PHASE_BITS-1:0]  phase;

  // Stage k is the register set feeding cell k; stage N feeds the output stage
  logic                 vld  [0:N];
  logic                 rdy  [0:N];
  logic signed [W-1:0]  xv   [0:N];
  logic signed [W-1:0]  yv   [0:N];
  logic [Z_BITS-1:0]    zv   [0:N];
  iqa_ctl_t             ctl  [0:N];
  logic [N:0]           vld_vec;

  assign i_sample = in_tdata[SAMPLE_BITS-1:0];
  assign q_sample = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  iqa_pre #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .W          (W)
  ) u_pre (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .i_sample   (i_sample),
    .q_sample   (q_sample),
    .last_sample(in_tlast),
    .out_valid  (vld[0]),
    .out_ready  (rdy[0]),
    .x_out      (xv[0]),
    .y_out      (yv[0]),
    .z_out      (zv[0]),
    .ctl_out    (ctl[0])
  );

  // Row of micro-rotation cells
  generate
    for (genvar k = 0; k < N; k++) begin : g_cell
      iqa_cell #(
        .W  (W),
        .IDX(k)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld[k]),
        .in_ready (rdy[k]),
        .x_in     (xv[k]),
        .y_in     (yv[k]),
        .z_in     (zv[k]),
        .ctl_in   (ctl[k]),
        .out_valid(vld[k+1]),
        .out_ready(rdy[k+1]),
        .x_out    (xv[k+1]),
        .y_out    (yv[k+1]),
        .z_out    (zv[k+1]),
        .ctl_out  (ctl[k+1])
      );
    end
    for (genvar j = 0; j <= N; j++) begin : g_vld
      assign vld_vec[j] = vld[j];
    end
  endgenerate

  iqa_post #(
    .PHASE_BITS(PHASE_BITS)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vld[N]),
    .in_ready   (rdy[N]),
    .z_in       (zv[N]),
    .ctl_in     (ctl[N]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .phase      (phase),
    .last_result(out_tlast)
  );

  assign out_tdata = OUT_W'($unsigned(phase));

  // An empty output register lets the whole row advance
  `IQA_ASSERT_IMP(a_ready_when_out_empty, clk, rst_n, !out_tvalid, in_tready)
  // With every cell full and the output stalled, no item may enter
  `IQA_ASSERT_IMP(a_full_blocks_input, clk, rst_n,
                  (&vld_vec) && out_tvalid && !out_tready, !in_tready)
  // Reset empties the output register
  `IQA_ASSERT_NXT(a_reset_clears_out, clk, !rst_n, !out_tvalid)
  // Reset empties the pre-rotation register
  `IQA_ASSERT_NXT(a_reset_clears_pre, clk, !rst_n, !vld[0])

endmodule

`default_nettype wire
